// ----- rtl/core/limit_order_book_matcher_macros.svh -----
// Assertion macros for the order book matcher.
`ifndef LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`ifndef ASSERT_OFF
`define LOBM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lobm assertion failed");
`define LOBM_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("lobm reset assertion failed");
`else
`define LOBM_ASSERT(name, prop)
`define LOBM_ASSERT_RST(name, prop)
`endif
`endif

// ----- rtl/core/lobm_pkg.sv -----
package lobm_pkg;

  localparam int MaxOrders = 64;
  localparam int SlotW     = $clog2(MaxOrders);
  localparam int CntW      = SlotW + 1;
  localparam int IdW       = 24;
  localparam int PriceW    = 10;
  localparam int QtyW      = 16;
  localparam int StampW    = 32;
  localparam int ResultCap = 64;
  localparam logic [IdW-1:0] IdMax = '1;

  typedef enum logic [1:0] {
    REQ_LIMIT  = 2'd0,
    REQ_MARKET = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_MODIFY = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_CANCEL, S_CHK, S_SCAN, S_FILL, S_POST, S_POP, S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic              side;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic [IdW-1:0]    order_id;
  } req_t;

  typedef struct packed {
    logic              result_kind;
    logic [IdW-1:0]    buy_id;
    logic [IdW-1:0]    sell_id;
    logic [PriceW-1:0] trade_price;
    logic [QtyW-1:0]   trade_qty;
    logic [IdW-1:0]    new_order_id;
    logic [QtyW-1:0]   rested_qty;
    logic              book_full;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic              side;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic [StampW-1:0] stamp;
  } entry_t;

endpackage

// ----- rtl/core/limit_order_book_matcher.sv -----
// Price-time priority order book with matching.
// Input channel: in_valid_i / in_stall_o carry one request item (limit, market,
// cancel or modify). Output channel: out_valid_o / out_stall_i carry result
// items; each request yields one trade item per fill, or a single status item,
// and the final item of a request has last set.
// Resting orders live in a 64-entry store memory (one read port, registered
// data). Finding the best opposite order, or the target of a cancel/modify,
// is a sweep of all 64 slots through that port.
// A cancel is a sweep for its target, then its drop (skipped for an unknown id).
// Each fill is a check, a sweep and a fill; unless the quantity is used up or
// the result cap is reached, a last check and sweep close the request, and a
// limit remainder that rests then takes a free slot. A modify adds its search,
// and a zero quantity order skips the sweep and the fill. One request
// is processed at a time; in_stall_o is high until the final item has been
// loaded into the output register.
// Time priority within a price comes from an insertion stamp kept per entry.
// Reset empties the book, frees all slots and restarts ids at 1; no clearing
// pass is needed. A stalled receiver holds the output register and the block
// waits before loading the next item; nothing is dropped.
module limit_order_book_matcher (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lobm_pkg::req_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lobm_pkg::res_t out_item_o
);
  import lobm_pkg::*;
  `include "limit_order_book_matcher_macros.svh"

  state_e state_q, state_d;

  // request context
  req_t              req_q, req_d;
  logic              side_q, side_d;
  logic [QtyW-1:0]   qty_q, qty_d;
  logic [IdW-1:0]    nid_q, nid_d;
  logic              mkt_q, mkt_d;
  logic [CntW-1:0]   fills_q, fills_d;
  logic [IdW-1:0]    next_id_q, next_id_d;
  logic [StampW-1:0] stamp_q, stamp_d;
  logic [QtyW-1:0]   rested_q, rested_d;
  logic              full_q, full_d;

  // sweep over the store
  logic [CntW-1:0]   scan_q, scan_d;
  logic              rd_vld_q, rd_vld_d;
  logic [SlotW-1:0]  rd_slot_q;
  entry_t            store_rd_q;
  logic              found_q, found_d;
  logic [SlotW-1:0]  found_slot_q, found_slot_d;
  logic              found_side_q, found_side_d;
  logic              best_vld_q, best_vld_d;
  entry_t            best_q, best_d;
  logic [SlotW-1:0]  best_slot_q, best_slot_d;

  // free slot stack
  logic [CntW-1:0]   free_cnt_q, free_cnt_d;
  logic [CntW-1:0]   low_q, low_d;
  logic [SlotW-1:0]  stk_rd_q;
  logic [SlotW-1:0]  cnt_m1;
  logic              stk_we;
  logic [SlotW-1:0]  stk_wd;

  // store and valid bits
  entry_t            store_mem [MaxOrders];
  logic [SlotW-1:0]  stack_mem [MaxOrders];
  logic [MaxOrders-1:0] valid_q;
  logic              st_we;
  logic [SlotW-1:0]  st_wa;
  entry_t            st_wd;
  logic              vclr, vset;
  logic [SlotW-1:0]  vclr_slot, vset_slot;

  // output path
  logic              pend_vld_q, pend_vld_d;
  res_t              pend_q, pend_d;
  logic              out_vld_q, out_vld_d;
  res_t              out_q, out_d;
  logic              can_load;

  // sweep helpers
  logic              cand_ok, hit, take, better, scan_end, bound_fail;
  logic [StampW-1:0] age_diff;
  logic [QtyW-1:0]   fill_qty, rem_qty;
  logic [CntW-1:0]   pop_idx;
  logic [SlotW-1:0]  pop_slot;
  res_t              trade;

  assign can_load    = !out_vld_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign cnt_m1      = free_cnt_q[SlotW-1:0] - SlotW'(1);

  assign cand_ok  = rd_vld_q && valid_q[rd_slot_q];
  assign hit      = cand_ok && (store_rd_q.id == req_q.order_id) && !found_q;
  assign age_diff = store_rd_q.stamp - best_q.stamp;
  // buyers want the lowest ask, sellers the highest bid; older stamp breaks ties
  always_comb begin
    if (side_q == 1'b0) begin
      better = (store_rd_q.price < best_q.price);
    end else begin
      better = (store_rd_q.price > best_q.price);
    end
    if (store_rd_q.price == best_q.price) begin
      better = age_diff[StampW-1];
    end
  end
  assign take     = cand_ok && (store_rd_q.side == !side_q) && (!best_vld_q || better);
  assign scan_end = scan_q[CntW-1] && !rd_vld_q;
  assign bound_fail = !mkt_q && (side_q == 1'b0 ? (best_q.price > req_q.price)
                                                : (best_q.price < req_q.price));
  assign fill_qty = (qty_q < best_q.qty) ? qty_q : best_q.qty;
  assign rem_qty  = best_q.qty - fill_qty;
  assign pop_idx  = free_cnt_q - CntW'(1);
  assign pop_slot = (pop_idx >= low_q) ? stk_rd_q : SlotW'(MaxOrders - 1) - pop_idx[SlotW-1:0];

  always_comb begin
    trade             = '0;
    trade.result_kind = 1'b0;
    trade.buy_id      = (side_q == 1'b0) ? nid_q : best_q.id;
    trade.sell_id     = (side_q == 1'b0) ? best_q.id : nid_q;
    trade.trade_price = best_q.price;
    trade.trade_qty   = fill_qty;
    trade.new_order_id = nid_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.req_type == REQ_LIMIT || in_item_i.req_type == REQ_MARKET) begin
            state_d = S_CHK;
          end else begin
            state_d = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (scan_end) state_d = found_q ? S_CANCEL : S_DONE;
      end
      S_CANCEL: state_d = (req_q.req_type == REQ_CANCEL) ? S_DONE : S_CHK;
      S_CHK: begin
        if (qty_q == '0 || fills_q == CntW'(ResultCap)) state_d = S_POST;
        else                                           state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_end) state_d = (best_vld_q && !bound_fail) ? S_FILL : S_POST;
      end
      S_FILL: begin
        if (!pend_vld_q || can_load) state_d = S_CHK;
      end
      S_POST: begin
        if (mkt_q || qty_q == '0 || free_cnt_q == '0) state_d = S_DONE;
        else                                         state_d = S_POP;
      end
      S_POP:  state_d = S_DONE;
      S_DONE: begin
        if (can_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    req_d = req_q; side_d = side_q; qty_d = qty_q; nid_d = nid_q; mkt_d = mkt_q;
    fills_d = fills_q; next_id_d = next_id_q; stamp_d = stamp_q;
    rested_d = rested_q; full_d = full_q;
    found_d = found_q; found_slot_d = found_slot_q; found_side_d = found_side_q;
    best_vld_d = best_vld_q; best_d = best_q; best_slot_d = best_slot_q;
    free_cnt_d = free_cnt_q; low_d = low_q;
    pend_vld_d = pend_vld_q; pend_d = pend_q;
    out_d = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    stk_we = 1'b0; stk_wd = '0;
    st_we = 1'b0; st_wa = '0; st_wd = best_q;
    vclr = 1'b0; vclr_slot = '0; vset = 1'b0; vset_slot = '0;
    rd_vld_d = (state_q == S_FIND || state_q == S_SCAN) && !scan_q[CntW-1];
    scan_d   = rd_vld_d ? scan_q + CntW'(1) : (state_q == S_FIND || state_q == S_SCAN)
               ? scan_q : '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_item_i; side_d = in_item_i.side; qty_d = in_item_i.qty;
          mkt_d = (in_item_i.req_type == REQ_MARKET);
          fills_d = '0; pend_vld_d = 1'b0; rested_d = '0; full_d = 1'b0;
          found_d = 1'b0; nid_d = '0;
          if (in_item_i.req_type == REQ_LIMIT || in_item_i.req_type == REQ_MARKET) begin
            nid_d     = next_id_q;
            next_id_d = (next_id_q >= IdMax) ? IdW'(1) : next_id_q + IdW'(1);
          end
        end
      end
      S_FIND: begin
        if (hit) begin
          found_d = 1'b0 | 1'b1; found_slot_d = rd_slot_q; found_side_d = store_rd_q.side;
        end
      end
      S_CANCEL: begin
        // drop the target and return its slot
        vclr = 1'b1; vclr_slot = found_slot_q;
        stk_we = 1'b1; stk_wd = found_slot_q;
        free_cnt_d = free_cnt_q + CntW'(1);
        if (req_q.req_type == REQ_MODIFY) begin
          side_d    = found_side_q;
          nid_d     = next_id_q;
          next_id_d = (next_id_q >= IdMax) ? IdW'(1) : next_id_q + IdW'(1);
        end
      end
      S_CHK: best_vld_d = 1'b0;
      S_SCAN: begin
        if (take) begin
          best_vld_d = 1'b1; best_d = store_rd_q; best_slot_d = rd_slot_q;
        end
      end
      S_FILL: begin
        if (!pend_vld_q || can_load) begin
          if (pend_vld_q) begin
            out_d = pend_q; out_vld_d = 1'b1;
          end
          pend_d = trade; pend_vld_d = 1'b1;
          qty_d = qty_q - fill_qty;
          fills_d = fills_q + CntW'(1);
          if (rem_qty == '0) begin
            vclr = 1'b1; vclr_slot = best_slot_q;
            stk_we = 1'b1; stk_wd = best_slot_q;
            free_cnt_d = free_cnt_q + CntW'(1);
          end else begin
            st_we = 1'b1; st_wa = best_slot_q;
            st_wd = best_q; st_wd.qty = rem_qty;
          end
        end
      end
      S_POST: begin
        if (!mkt_q && qty_q != '0 && free_cnt_q == '0) full_d = 1'b1;
      end
      S_POP: begin
        // rest the remainder at its limit, newest stamp
        st_we = 1'b1; st_wa = pop_slot;
        st_wd.id = nid_q; st_wd.side = side_q; st_wd.price = req_q.price;
        st_wd.qty = qty_q; st_wd.stamp = stamp_q;
        vset = 1'b1; vset_slot = pop_slot;
        free_cnt_d = pop_idx;
        if (pop_idx < low_q) low_d = pop_idx;
        stamp_d = stamp_q + StampW'(1);
        rested_d = qty_q;
      end
      S_DONE: begin
        if (can_load) begin
          if (pend_vld_q) begin
            out_d = pend_q;
          end else begin
            out_d = '0; out_d.result_kind = 1'b1; out_d.new_order_id = nid_q;
          end
          out_d.rested_qty = rested_q; out_d.book_full = full_q; out_d.last = 1'b1;
          out_vld_d = 1'b1; pend_vld_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_wa] <= st_wd;
    store_rd_q <= store_mem[scan_q[SlotW-1:0]];
    if (stk_we) stack_mem[free_cnt_q[SlotW-1:0]] <= stk_wd;
    stk_rd_q <= stack_mem[cnt_m1];
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; qty_q <= qty_d; nid_q <= nid_d;
    rested_q <= rested_d; rd_slot_q <= scan_q[SlotW-1:0];
    found_slot_q <= found_slot_d; found_side_q <= found_side_d;
    best_d_reg: begin
      best_q <= best_d; best_slot_q <= best_slot_d;
    end
    pend_q <= pend_d; out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; side_q <= 1'b0; mkt_q <= 1'b0; fills_q <= '0;
      next_id_q <= IdW'(1); stamp_q <= '0; full_q <= 1'b0;
      scan_q <= '0; rd_vld_q <= 1'b0; found_q <= 1'b0; best_vld_q <= 1'b0;
      free_cnt_q <= CntW'(MaxOrders); low_q <= CntW'(MaxOrders);
      pend_vld_q <= 1'b0; out_vld_q <= 1'b0; valid_q <= '0;
    end else begin
      state_q <= state_d; side_q <= side_d; mkt_q <= mkt_d; fills_q <= fills_d;
      next_id_q <= next_id_d; stamp_q <= stamp_d; full_q <= full_d;
      scan_q <= scan_d; rd_vld_q <= rd_vld_d; found_q <= found_d;
      best_vld_q <= best_vld_d; free_cnt_q <= free_cnt_d; low_q <= low_d;
      pend_vld_q <= pend_vld_d; out_vld_q <= out_vld_d;
      if (vclr) valid_q[vclr_slot] <= 1'b0;
      if (vset) valid_q[vset_slot] <= 1'b1;
    end
  end

  `LOBM_ASSERT(a_slot_balance, ($countones(valid_q) + int'(free_cnt_q)) == MaxOrders)
  `LOBM_ASSERT(a_cnt_range, (free_cnt_q <= CntW'(MaxOrders)) && (low_q <= CntW'(MaxOrders)))
  `LOBM_ASSERT(a_idle_no_pend, (state_q == S_IDLE) |-> !pend_vld_q)
  `LOBM_ASSERT(a_fill_cap, fills_q <= CntW'(ResultCap))
  `LOBM_ASSERT(a_fill_needs_best, (state_q == S_FILL) |-> best_vld_q && (qty_q != '0))
  `LOBM_ASSERT_RST(a_reset_idle, $rose(rst_ni) |-> (state_q == S_IDLE) && !out_vld_q)

endmodule

// ----- sim/limit_order_book_matcher_tb.sv -----
module limit_order_book_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lobm_pkg::*;

  localparam int NumLevels = 1024;
  localparam int NoSlot    = MaxOrders;
  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  res_t out_item_o;

  limit_order_book_matcher dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Book model: slot store, per-level FIFOs, free-slot stack and id counter.
  logic            bk_valid [MaxOrders];
  logic [IdW-1:0]  bk_id    [MaxOrders];
  logic            bk_side  [MaxOrders];
  logic [PriceW-1:0] bk_price [MaxOrders];
  logic [QtyW-1:0] bk_qty   [MaxOrders];
  int              bk_link  [MaxOrders];
  int              lvl_head [2][NumLevels];
  int              lvl_tail [2][NumLevels];
  bit              lvl_busy [2][NumLevels];
  int              free_stack [MaxOrders];
  int              free_cnt;
  logic [IdW-1:0]  id_next;

  res_t expected_results[$];
  res_t fills[$];

  int  errors = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_trades = 0;
  int  n_full = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_recv = 1'b0;

  function automatic void book_clear();
    for (int i = 0; i < MaxOrders; i++) begin
      bk_valid[i] = 1'b0;
      bk_link[i] = NoSlot;
      free_stack[i] = MaxOrders - 1 - i;
    end
    for (int p = 0; p < NumLevels; p++)
      for (int s = 0; s < 2; s++) begin
        lvl_head[s][p] = NoSlot;
        lvl_tail[s][p] = NoSlot;
        lvl_busy[s][p] = 1'b0;
      end
    free_cnt = MaxOrders;
    id_next = IdW'(1);
  endfunction

  function automatic logic [IdW-1:0] claim_id();
    logic [IdW-1:0] id;
    id = id_next;
    id_next = (id_next == IdMax) ? IdW'(1) : id_next + IdW'(1);
    return id;
  endfunction

  function automatic void free_slot(int s);
    bk_valid[s] = 1'b0;
    if (free_cnt < MaxOrders) begin
      free_stack[free_cnt] = s;
      free_cnt++;
    end
  endfunction

  function automatic void queue_slot(int s);
    int sd;
    int p;
    sd = int'(bk_side[s]);
    p = int'(bk_price[s]);
    bk_link[s] = NoSlot;
    if (!lvl_busy[sd][p]) begin
      lvl_head[sd][p] = s;
      lvl_busy[sd][p] = 1'b1;
    end else begin
      bk_link[lvl_tail[sd][p]] = s;
    end
    lvl_tail[sd][p] = s;
  endfunction

  function automatic void dequeue_slot(int s);
    int sd;
    int p;
    int cur;
    int prev;
    sd = int'(bk_side[s]);
    p = int'(bk_price[s]);
    prev = NoSlot;
    if (!lvl_busy[sd][p]) return;
    cur = lvl_head[sd][p];
    while (cur != NoSlot && cur != s) begin
      prev = cur;
      cur = bk_link[cur];
    end
    if (cur == NoSlot) return;
    if (prev == NoSlot) lvl_head[sd][p] = bk_link[s];
    else bk_link[prev] = bk_link[s];
    if (lvl_tail[sd][p] == s) lvl_tail[sd][p] = prev;
    if (prev == NoSlot && bk_link[s] == NoSlot) lvl_busy[sd][p] = 1'b0;
  endfunction

  function automatic void add_fill(logic [IdW-1:0] b, logic [IdW-1:0] sl,
                                   logic [PriceW-1:0] p, logic [QtyW-1:0] q,
                                   logic [IdW-1:0] nid, logic kind);
    res_t r;
    r = '0;
    r.result_kind = kind;
    r.buy_id = b;
    r.sell_id = sl;
    r.trade_price = p;
    r.trade_qty = q;
    r.new_order_id = nid;
    fills.insert(fills.size(), r);
  endfunction

  // Sweep the opposite side best price first; return the quantity left.
  function automatic int sweep_book(logic side, bit bounded, int lim, int qty,
                                    logic [IdW-1:0] nid);
    int opp;
    int p;
    int s;
    int t;
    bit found;
    opp = side ? 0 : 1;
    while (qty > 0 && fills.size() < ResultCap) begin
      found = 1'b0;
      if (opp == 1) begin
        for (p = 0; p < NumLevels; p++) if (lvl_busy[1][p]) begin found = 1'b1; break; end
      end else begin
        for (p = NumLevels - 1; p >= 0; p--) if (lvl_busy[0][p]) begin found = 1'b1; break; end
      end
      if (!found) break;
      if (bounded && ((side == 1'b0 && p > lim) || (side == 1'b1 && p < lim))) break;
      s = lvl_head[opp][p];
      t = (qty < int'(bk_qty[s])) ? qty : int'(bk_qty[s]);
      if (side == 1'b0) add_fill(nid, bk_id[s], PriceW'(p), QtyW'(t), nid, 1'b0);
      else add_fill(bk_id[s], nid, PriceW'(p), QtyW'(t), nid, 1'b0);
      qty -= t;
      bk_qty[s] = bk_qty[s] - QtyW'(t);
      if (bk_qty[s] == 0) begin
        dequeue_slot(s);
        free_slot(s);
      end
    end
    return qty;
  endfunction

  function automatic void close_request(logic [IdW-1:0] nid, int rested, bit full);
    if (fills.size() == 0) add_fill('0, '0, '0, '0, nid, 1'b1);
    fills[fills.size()-1].rested_qty = QtyW'(rested);
    fills[fills.size()-1].book_full = full;
    fills[fills.size()-1].last = 1'b1;
    n_trades += (fills[0].result_kind == 1'b0) ? fills.size() : 0;
    n_full += int'(full);
    foreach (fills[i]) expected_results.insert(expected_results.size(), fills[i]);
    fills.delete();
  endfunction

  function automatic void enter_limit(logic side, int price, int qty);
    logic [IdW-1:0] nid;
    int rested;
    int s;
    bit full;
    nid = claim_id();
    rested = 0;
    full = 1'b0;
    qty = sweep_book(side, 1'b1, price, qty, nid);
    if (qty > 0) begin
      if (free_cnt == 0) begin
        full = 1'b1;
      end else begin
        free_cnt--;
        s = free_stack[free_cnt];
        bk_valid[s] = 1'b1;
        bk_id[s] = nid;
        bk_side[s] = side;
        bk_price[s] = PriceW'(price);
        bk_qty[s] = QtyW'(qty);
        queue_slot(s);
        rested = qty;
      end
    end
    close_request(nid, rested, full);
  endfunction

  function automatic void predict_request(req_t rq);
    int s;
    logic [IdW-1:0] nid;
    fills.delete();
    case (req_type_e'(rq.req_type))
      REQ_LIMIT: enter_limit(rq.side, int'(rq.price), int'(rq.qty));
      REQ_MARKET: begin
        nid = claim_id();
        void'(sweep_book(rq.side, 1'b0, 0, int'(rq.qty), nid));
        close_request(nid, 0, 1'b0);
      end
      default: begin
        s = NoSlot;
        for (int i = 0; i < MaxOrders; i++)
          if (bk_valid[i] && bk_id[i] == rq.order_id) begin s = i; break; end
        if (s == NoSlot) begin
          close_request('0, 0, 1'b0);
        end else begin
          dequeue_slot(s);
          free_slot(s);
          if (rq.req_type == REQ_CANCEL) close_request('0, 0, 1'b0);
          else enter_limit(bk_side[s], int'(rq.price), int'(rq.qty));
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Offer one item, with a random pre-gap; predict it on acceptance.
  // The item stays offered after acceptance until the next call or stop_offer.
  task automatic send_request(req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= rq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(rq);
    n_items++;
  endtask

  // Withdraw the input after the last item of a sequence.
  task automatic stop_offer();
    in_valid_i <= 1'b0;
  endtask

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_item_o.new_order_id), 64'(0));
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_item_o.result_kind !== want.result_kind)
          report_mismatch("result_kind", 64'(out_item_o.result_kind), 64'(want.result_kind));
        if (out_item_o.buy_id !== want.buy_id)
          report_mismatch("buy_id", 64'(out_item_o.buy_id), 64'(want.buy_id));
        if (out_item_o.sell_id !== want.sell_id)
          report_mismatch("sell_id", 64'(out_item_o.sell_id), 64'(want.sell_id));
        if (out_item_o.trade_price !== want.trade_price)
          report_mismatch("trade_price", 64'(out_item_o.trade_price), 64'(want.trade_price));
        if (out_item_o.trade_qty !== want.trade_qty)
          report_mismatch("trade_qty", 64'(out_item_o.trade_qty), 64'(want.trade_qty));
        if (out_item_o.new_order_id !== want.new_order_id)
          report_mismatch("new_order_id", 64'(out_item_o.new_order_id),
                          64'(want.new_order_id));
        if (out_item_o.rested_qty !== want.rested_qty)
          report_mismatch("rested_qty", 64'(out_item_o.rested_qty), 64'(want.rested_qty));
        if (out_item_o.book_full !== want.book_full)
          report_mismatch("book_full", 64'(out_item_o.book_full), 64'(want.book_full));
        if (out_item_o.last !== want.last)
          report_mismatch("last", 64'(out_item_o.last), 64'(want.last));
      end
    end
  end

  // Watchdog: end the run after a long stretch with no handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic req_t make_req(req_type_e k, logic sd, int p, int q, int id);
    req_t r;
    r.req_type = k;
    r.side = sd;
    r.price = PriceW'(p);
    r.qty = QtyW'(q);
    r.order_id = IdW'(id);
    return r;
  endfunction

  // Pick an id that is probably resting, or else a random one.
  function automatic int pick_id();
    int s;
    s = $urandom_range(MaxOrders - 1);
    if ($urandom_range(9) < 8 && bk_valid[s]) return int'(bk_id[s]);
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(id_next + 2);
  endfunction

  // Well-formed random request near a mid price so books cross often.
  function automatic req_t random_req();
    int k;
    int p;
    int q;
    k = $urandom_range(99);
    p = ($urandom_range(19) == 0) ? $urandom_range(1023) : 500 + $urandom_range(20);
    q = ($urandom_range(19) == 0) ? $urandom : $urandom_range(1, 300);
    if (k < 55) return make_req(REQ_LIMIT, 1'($urandom_range(1)), p, q, $urandom);
    if (k < 67) return make_req(REQ_MARKET, 1'($urandom_range(1)), $urandom, q, $urandom);
    if (k < 85) return make_req(REQ_CANCEL, 1'($urandom), $urandom, $urandom, pick_id());
    return make_req(REQ_MODIFY, 1'($urandom), p, q, pick_id());
  endfunction

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Field extremes, zero quantity, every request kind and unknown ids.
  task automatic test_directed();
    send_request(make_req(REQ_LIMIT, 1'b0, 0, 0, 0));
    send_request(make_req(REQ_CANCEL, 1'b0, 0, 0, 24'hFFFFFF));
    send_request(make_req(REQ_MODIFY, 1'b1, 1023, 16'hFFFF, 0));
    send_request(make_req(REQ_LIMIT, 1'b1, 1023, 16'hFFFF, 24'hFFFFFF));
    send_request(make_req(REQ_LIMIT, 1'b1, 100, 10, 0));
    send_request(make_req(REQ_LIMIT, 1'b1, 100, 20, 0));
    send_request(make_req(REQ_LIMIT, 1'b1, 90, 5, 0));
    send_request(make_req(REQ_LIMIT, 1'b0, 100, 30, 0));
    send_request(make_req(REQ_LIMIT, 1'b0, 0, 7, 0));
    send_request(make_req(REQ_MARKET, 1'b1, 1023, 16'hFFFF, 24'hFFFFFF));
    send_request(make_req(REQ_MARKET, 1'b0, 0, 3, 0));
    send_request(make_req(REQ_MARKET, 1'b1, 0, 0, 0));
    send_request(make_req(REQ_LIMIT, 1'b0, 200, 50, 0));
    send_request(make_req(REQ_MODIFY, 1'b0, 300, 40, int'(id_next) - 1));
    send_request(make_req(REQ_MODIFY, 1'b0, 300, 0, int'(id_next) - 1));
    send_request(make_req(REQ_LIMIT, 1'b0, 400, 9, 0));
    send_request(make_req(REQ_CANCEL, 1'b1, 1023, 16'hFFFF, int'(id_next) - 1));
    send_request(make_req(REQ_CANCEL, 1'b1, 0, 0, int'(id_next) - 1));
    send_request(make_req(REQ_MODIFY, 1'b1, 5, 5, 24'h123456));
    send_request(make_req(REQ_LIMIT, 1'b0, 1023, 16'hFFFF, 0));
    send_request(make_req(REQ_MARKET, 1'b1, 0, 16'hFFFF, 0));
    stop_offer();
    drain_results();
  endtask

  // Fill the store past capacity, then sweep it with two large market orders.
  task automatic test_full_book();
    for (int i = 0; i < MaxOrders + 3; i++)
      send_request(make_req(REQ_LIMIT, 1'b1, 600 + (i % 4), 1 + i, 0));
    send_request(make_req(REQ_MARKET, 1'b0, 0, 16'hFFFF, 0));
    send_request(make_req(REQ_MARKET, 1'b0, 0, 16'hFFFF, 0));
    stop_offer();
    drain_results();
  endtask

  // Hold the receiver off for a long stretch while items keep arriving.
  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (1500) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) send_request(random_req());
        stop_offer();
      end
    join
    drain_results();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_request(random_req());
    stop_offer();
    drain_results();
  endtask

  initial begin
    book_clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 28;
    recv_idle_pct = 84;
    test_directed();
    test_full_book();
    test_random(60);
    send_idle_pct = 84;
    recv_idle_pct = 28;
    test_random(50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(45);
    $display("Covered %0d requests, %0d results (%0d trades, %0d book-full drops).",
             n_items, n_results, n_trades, n_full);
    $display("Modes: both-side idling, full store, long output hold-off.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
